>>> sv/ncd_pkg.sv
// Shared constants and types for the nearest-car elevator dispatcher.
// No dependencies; imported by every module of the block.
package ncd_pkg;

   localparam int MAX_CARS   = 8;
   localparam int MAX_FLOORS = 16;
   localparam int CAR_W      = 3;   // width of the car field
   localparam int FLOOR_W    = 5;   // width of a floor number
   localparam int FCNT_W     = 5;   // floor_count register width
   localparam int CCNT_W     = 4;   // car_count register width
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] REG_FLOOR_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CAR_COUNT   = 1'b1;

   localparam logic [FCNT_W-1:0]  FLOOR_COUNT_RST = 5'd15;
   localparam logic [CCNT_W-1:0]  CAR_COUNT_RST   = 4'd6;
   localparam logic [FLOOR_W-1:0] FLOOR_RST       = 5'd1;
   localparam logic [FLOOR_W-1:0] FLOOR_MIN       = 5'd2;
   localparam logic [FLOOR_W-1:0] FLOOR_MAX       = FLOOR_W'(MAX_FLOORS);
   localparam logic [CCNT_W-1:0]  CARS_MAX        = CCNT_W'(MAX_CARS);

   // write port into the car floor table
   typedef struct packed {
      logic               en;
      logic [CAR_W-1:0]   idx;
      logic [FLOOR_W-1:0] floor;
   } car_wr_type;

   // result of the shared compare / step unit
   typedef struct packed {
      logic [FLOOR_W-1:0] span;
      logic               up;
      logic               eq;
      logic [FLOOR_W-1:0] step;
   } alu_res_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_MOVE = 3'b100
   } state_type;

endpackage

>>> sv/nearest_car_elevator_dispatch.sv
// A valid item scans the cars one per cycle, then steps the chosen car one floor per cycle
// with one result per floor moved and no result in the cycle where the pickup leg ends
// (ahead of the first result when the chosen car already waits at the pickup floor).
// A new item is taken only while idle; a rejected item gives a single result, no movement.
// Results cannot be stalled. Synchronous reset: idle, every car at floor 1, defaults loaded.
module nearest_car_elevator_dispatch
   import ncd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FLOOR_W-1:0]    req_pickup_floor,
   input  logic [FLOOR_W-1:0]    req_dest_floor,
   output logic                  rsp_strobe,
   output logic [CAR_W-1:0]      rsp_car,
   output logic [FLOOR_W-1:0]    rsp_floor_now,
   output logic                  rsp_moving_up,
   output logic                  rsp_delivery_leg,
   output logic                  rsp_rejected,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [FCNT_W-1:0]  floor_count_ff;
   logic [CCNT_W-1:0]  car_count_ff;
   logic [FLOOR_W-1:0] floors;
   logic [CAR_W-1:0]   last_car;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_count_ff <= FLOOR_COUNT_RST;
         car_count_ff   <= CAR_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FLOOR_COUNT: floor_count_ff <= csr_wdata[FCNT_W-1:0];
            REG_CAR_COUNT:   car_count_ff   <= csr_wdata[CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the registers into their working range
   always_comb begin
      priority if (floor_count_ff < FLOOR_MIN) begin
         floors = FLOOR_MIN;
      end else if (floor_count_ff > FLOOR_MAX) begin
         floors = FLOOR_MAX;
      end else begin
         floors = floor_count_ff;
      end
      priority if (car_count_ff == '0) begin
         last_car = '0;
      end else if (car_count_ff > CARS_MAX) begin
         last_car = CAR_W'(MAX_CARS - 1);
      end else begin
         last_car = CAR_W'(car_count_ff - CCNT_W'(1));
      end
   end

   ncd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .floors           (floors),
      .last_car         (last_car),
      .start            (start),
      .busy             (busy),
      .req_pickup_floor (req_pickup_floor),
      .req_dest_floor   (req_dest_floor),
      .rsp_strobe       (rsp_strobe),
      .rsp_car          (rsp_car),
      .rsp_floor_now    (rsp_floor_now),
      .rsp_moving_up    (rsp_moving_up),
      .rsp_delivery_leg (rsp_delivery_leg),
      .rsp_rejected     (rsp_rejected),
      .rsp_last         (rsp_last)
   );

endmodule

>>> sv/ncd_car_table.sv
// Floor of each car, one write port and one read port.
// Depends on ncd_pkg.
module ncd_car_table
   import ncd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  car_wr_type         wr,
   input  logic [CAR_W-1:0]   rd_idx,
   output logic [FLOOR_W-1:0] rd_floor
);

   logic [FLOOR_W-1:0] car_floor_ff [MAX_CARS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CARS; i++) begin
            car_floor_ff[i] <= FLOOR_RST;
         end
      end else if (wr.en) begin
         car_floor_ff[wr.idx] <= wr.floor;
      end
   end

   assign rd_floor = car_floor_ff[rd_idx];

endmodule

>>> sv/ncd_alu.sv
// Shared compare / step unit: distance, direction and next floor.
// Depends on ncd_pkg.
module ncd_alu
   import ncd_pkg::*;
(
   input  logic [FLOOR_W-1:0] a,
   input  logic [FLOOR_W-1:0] b,
   output alu_res_type        res
);

   always_comb begin
      res.up   = (a < b);
      res.eq   = (a == b);
      res.span = res.up ? (b - a) : (a - b);
      res.step = res.up ? (a + FLOOR_W'(1)) : (a - FLOOR_W'(1));
   end

endmodule

>>> sv/ncd_seq.sv
// Sequencer: validates a request, scans cars one per cycle, then steps the
// chosen car floor by floor. Depends on ncd_pkg, ncd_alu, ncd_car_table.
module ncd_seq
   import ncd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [FLOOR_W-1:0] floors,
   input  logic [CAR_W-1:0]   last_car,
   input  logic               start,
   output logic               busy,
   input  logic [FLOOR_W-1:0] req_pickup_floor,
   input  logic [FLOOR_W-1:0] req_dest_floor,
   output logic               rsp_strobe,
   output logic [CAR_W-1:0]   rsp_car,
   output logic [FLOOR_W-1:0] rsp_floor_now,
   output logic               rsp_moving_up,
   output logic               rsp_delivery_leg,
   output logic               rsp_rejected,
   output logic               rsp_last
);

   state_type          state_ff, state_in;
   logic [FLOOR_W-1:0] pickup_ff, pickup_in, dest_ff, dest_in;
   logic [CAR_W-1:0]   last_car_ff, last_car_in;
   logic [CAR_W-1:0]   idx_ff, idx_in, best_ff, best_in;
   logic [FLOOR_W-1:0] best_dist_ff, best_dist_in, cur_ff, cur_in;
   logic               leg_ff, leg_in;

   logic               strobe_ff, strobe_in;
   logic [CAR_W-1:0]   car_ff, car_in;
   logic [FLOOR_W-1:0] fnow_ff, fnow_in;
   logic               up_ff, up_in, dleg_ff, dleg_in, rej_ff, rej_in, last_ff, last_in;

   logic [FLOOR_W-1:0] rd_floor, alu_a, alu_b, target;
   alu_res_type        alu;
   car_wr_type         wr;
   logic               req_ok;

   ncd_car_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (idx_ff),
      .rd_floor (rd_floor)
   );

   ncd_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu)
   );

   assign target = leg_ff ? dest_ff : pickup_ff;
   assign alu_a  = (state_ff == ST_SCAN) ? rd_floor : cur_ff;
   assign alu_b  = (state_ff == ST_SCAN) ? pickup_ff : target;

   assign req_ok = (req_pickup_floor != '0) && (req_pickup_floor <= floors) &&
                   (req_dest_floor != '0) && (req_dest_floor <= floors) &&
                   (req_pickup_floor != req_dest_floor);

   always_comb begin
      state_in     = state_ff;
      pickup_in    = pickup_ff;
      dest_in      = dest_ff;
      last_car_in  = last_car_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      cur_in       = cur_ff;
      leg_in       = leg_ff;
      strobe_in    = 1'b0;
      car_in       = car_ff;
      fnow_in      = fnow_ff;
      up_in        = up_ff;
      dleg_in      = dleg_ff;
      rej_in       = rej_ff;
      last_in      = last_ff;
      wr           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_ok) begin
                  pickup_in   = req_pickup_floor;
                  dest_in     = req_dest_floor;
                  last_car_in = last_car;
                  idx_in      = '0;
                  state_in    = ST_SCAN;
               end else begin
                  // rejected item: one result, no movement
                  strobe_in = 1'b1;
                  car_in    = '0;
                  fnow_in   = '0;
                  up_in     = 1'b0;
                  dleg_in   = 1'b0;
                  rej_in    = 1'b1;
                  last_in   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // strict less-than keeps the lowest index on a tie
            if (idx_ff == '0 || alu.span < best_dist_ff) begin
               best_dist_in = alu.span;
               best_in      = idx_ff;
               cur_in       = rd_floor;
            end
            idx_in = idx_ff + CAR_W'(1);
            if (idx_ff == last_car_ff) begin
               leg_in   = 1'b0;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (alu.eq) begin
               leg_in = 1'b1;   // pickup reached, start delivery
            end else begin
               cur_in    = alu.step;
               wr.en     = 1'b1;
               wr.idx    = best_ff;
               wr.floor  = alu.step;
               strobe_in = 1'b1;
               car_in    = best_ff;
               fnow_in   = alu.step;
               up_in     = alu.up;
               dleg_in   = leg_ff;
               rej_in    = 1'b0;
               last_in   = leg_ff && (alu.span == FLOOR_W'(1));
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pickup_ff    <= pickup_in;
      dest_ff      <= dest_in;
      last_car_ff  <= last_car_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      cur_ff       <= cur_in;
      leg_ff       <= leg_in;
      car_ff       <= car_in;
      fnow_ff      <= fnow_in;
      up_ff        <= up_in;
      dleg_ff      <= dleg_in;
      rej_ff       <= rej_in;
      last_ff      <= last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_car          = car_ff;
   assign rsp_floor_now    = fnow_ff;
   assign rsp_moving_up    = up_ff;
   assign rsp_delivery_leg = dleg_ff;
   assign rsp_rejected     = rej_ff;
   assign rsp_last         = last_ff;

endmodule

>>> sv/ncd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
// Depends on ncd_pkg and nearest_car_elevator_dispatch.
module ncd_checker
   import ncd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [CAR_W-1:0]   rsp_car,
   input logic [FLOOR_W-1:0] rsp_floor_now,
   input logic               rsp_rejected,
   input logic               rsp_last
);

   a_rej_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rejected |-> rsp_last)
      else $error("rejected item without last");

   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rejected |-> rsp_car == '0 && rsp_floor_now == '0)
      else $error("rejected item carries nonzero car or floor");

   a_floor_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_rejected |-> rsp_floor_now != '0)
      else $error("move result with floor 0");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("idle while results still pending");

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe)
      else $error("result during first scan cycle");

endmodule

bind nearest_car_elevator_dispatch ncd_checker u_ncd_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_car       (rsp_car),
   .rsp_floor_now (rsp_floor_now),
   .rsp_rejected  (rsp_rejected),
   .rsp_last      (rsp_last)
);

>>> dv/testbench.sv
// Self-checking bench for nearest_car_elevator_dispatch: a directed table, then
// random dispatch requests under several floor/car settings, checked step by step.
// Depends on ncd_pkg and the dispatcher RTL.
module testbench;
   import ncd_pkg::*;

   typedef struct packed {
      logic [CAR_W-1:0]   car;
      logic [FLOOR_W-1:0] floor_now;
      logic               up;
      logic               leg;
      logic               rej;
      logic               last;
   } step_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [FLOOR_W-1:0]   a;       // pickup
      logic [FLOOR_W-1:0]   b;       // dest, or register data
      logic [CSR_IDX_W-1:0] idx;
      logic                 typed;   // exp holds the only result of the item
      step_type             exp;
   } stim_row_type;

   localparam step_type REJECT_STEP = '{3'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b1};
   localparam step_type FIRST_TRIP  = '{3'd0, 5'd2, 1'b1, 1'b1, 1'b0, 1'b1};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FLOOR_W-1:0]    req_pickup_floor = '0;
   logic [FLOOR_W-1:0]    req_dest_floor = '0;
   logic                  rsp_strobe;
   logic [CAR_W-1:0]      rsp_car;
   logic [FLOOR_W-1:0]    rsp_floor_now;
   logic                  rsp_moving_up;
   logic                  rsp_delivery_leg;
   logic                  rsp_rejected;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   nearest_car_elevator_dispatch dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mirror of the dispatcher
   logic [FCNT_W-1:0]  floor_cfg;
   logic [CCNT_W-1:0]  car_cfg;
   logic [FLOOR_W-1:0] car_pos [MAX_CARS];
   step_type           trip_steps_q [$];

   int errors = 0;
   int req_count = 0;
   int step_count = 0;
   int rej_count = 0;
   int csr_count = 0;

   function automatic int floors_in_use();
      if (floor_cfg < FLOOR_MIN) return FLOOR_MIN;
      if (floor_cfg > FLOOR_MAX) return FLOOR_MAX;
      return floor_cfg;
   endfunction

   function automatic int cars_in_use();
      if (car_cfg == 0) return 1;
      if (car_cfg > CARS_MAX) return CARS_MAX;
      return car_cfg;
   endfunction

   // nearest car wins, lowest index on a tie; one step per floor moved
   task automatic plan_trip(input logic [FLOOR_W-1:0] pickup, input logic [FLOOR_W-1:0] dest);
      int       floors;
      int       best;
      int       best_dist;
      int       d;
      int       target;
      logic     up;
      step_type s;
      floors = floors_in_use();
      best = 0;
      best_dist = 1000;
      if (pickup < 1 || pickup > floors || dest < 1 || dest > floors || pickup == dest) begin
         trip_steps_q.push_back(REJECT_STEP);
         return;
      end
      for (int i = 0; i < cars_in_use(); i++) begin
         d = (car_pos[i] > pickup) ? car_pos[i] - pickup : pickup - car_pos[i];
         if (d < best_dist) begin
            best_dist = d;
            best = i;
         end
      end
      for (int leg = 0; leg < 2; leg++) begin
         target = (leg == 1) ? dest : pickup;
         while (car_pos[best] != target) begin
            up = car_pos[best] < target;
            car_pos[best] = up ? car_pos[best] + 1'b1 : car_pos[best] - 1'b1;
            s.car       = CAR_W'(best);
            s.floor_now = car_pos[best];
            s.up        = up;
            s.leg       = (leg == 1);
            s.rej       = 1'b0;
            s.last      = (leg == 1) && (car_pos[best] == target);
            trip_steps_q.push_back(s);
         end
      end
   endtask

   task automatic report(input string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      step_type want;
      if (!reset && rsp_strobe) begin
         step_count++;
         if (rsp_rejected) rej_count++;
         if (trip_steps_q.size() == 0) begin
            report("result with nothing pending");
         end else begin
            want = trip_steps_q.pop_front();
            check_field("car", rsp_car, want.car);
            check_field("floor_now", rsp_floor_now, want.floor_now);
            check_field("moving_up", rsp_moving_up, want.up);
            check_field("delivery_leg", rsp_delivery_leg, want.leg);
            check_field("rejected", rsp_rejected, want.rej);
            check_field("last", rsp_last, want.last);
         end
      end
   end

   // raises start with the item and returns at the edge that takes it; start stays high
   task automatic send_request(input logic [FLOOR_W-1:0] pickup,
                               input logic [FLOOR_W-1:0] dest,
                               input logic typed, input step_type exp);
      int n0;
      @(negedge clock);
      start = 1'b1;
      req_pickup_floor = pickup;
      req_dest_floor = dest;
      do @(posedge clock); while (busy);
      req_count++;
      n0 = trip_steps_q.size();
      plan_trip(pickup, dest);
      if (typed) begin
         while (trip_steps_q.size() > n0) void'(trip_steps_q.pop_back());
         trip_steps_q.push_back(exp);
      end
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drop start and let the block finish everything pending
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (trip_steps_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      csr_count++;
      if (idx == REG_FLOOR_COUNT) floor_cfg = data[FCNT_W-1:0];
      else car_cfg = data[CCNT_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      stim_row_type       dir_rows [$];
      stim_row_type       row;
      logic [FLOOR_W-1:0] p;
      logic [FLOOR_W-1:0] d;
      int                 floors;
      int                 gap;
      bit                 idling;

      floor_cfg = FLOOR_COUNT_RST;
      car_cfg = CAR_COUNT_RST;
      for (int i = 0; i < MAX_CARS; i++) car_pos[i] = FLOOR_RST;

      // after reset: 15 floors, 6 cars, all at floor 1
      dir_rows.push_back('{ROW_REQ, 5'd1, 5'd2, REG_FLOOR_COUNT, 1'b1, FIRST_TRIP});
      dir_rows.push_back('{ROW_REQ, 5'd0, 5'd3, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd3, 5'd3, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd16, 5'd2, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd2, 5'd31, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      // a car already waits at the pickup floor
      dir_rows.push_back('{ROW_REQ, 5'd1, 5'd15, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd15, 5'd1, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd16, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd8, REG_CAR_COUNT, 1'b0, REJECT_STEP});
      // long trips: a long pickup leg up, full delivery leg down, then back up
      dir_rows.push_back('{ROW_REQ, 5'd16, 5'd1, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd1, 5'd16, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      // zero counts clamp to 2 floors, 1 car; car 0 sits above the top floor
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd0, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd0, REG_CAR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd2, 5'd1, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd3, 5'd1, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd1, 5'd2, REG_FLOOR_COUNT, 1'b1, FIRST_TRIP});
      // oversized counts clamp to 16 floors, 8 cars
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd31, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_CSR, 5'd0, 5'd31, REG_CAR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd31, 5'd1, REG_FLOOR_COUNT, 1'b1, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd16, 5'd15, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});
      dir_rows.push_back('{ROW_REQ, 5'd8, 5'd9, REG_FLOOR_COUNT, 1'b0, REJECT_STEP});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            drain();
            csr_write(row.idx, row.b);
         end else begin
            send_request(row.a, row.b, row.typed, row.exp);
         end
      end

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin
               csr_write(REG_FLOOR_COUNT, 5'd16);
               csr_write(REG_CAR_COUNT, 5'd8);
            end
            1: begin
               csr_write(REG_FLOOR_COUNT, 5'd2);
               csr_write(REG_CAR_COUNT, 5'd1);
            end
            default: begin
               csr_write(REG_FLOOR_COUNT, CSR_DATA_W'($urandom_range(0, 31)));
               csr_write(REG_CAR_COUNT, CSR_DATA_W'($urandom_range(0, 31)));
            end
         endcase
         floors = floors_in_use();
         idling = (phase != 0);   // phase 0 runs back to back
         for (int n = 0; n < 56; n++) begin
            if ($urandom_range(99) < 80) begin
               p = FLOOR_W'($urandom_range(1, floors));
               d = FLOOR_W'($urandom_range(1, floors - 1));
               if (d >= p) d = d + 1'b1;
            end else begin
               p = FLOOR_W'($urandom_range(0, 31));
               d = ($urandom_range(3) == 0) ? p : FLOOR_W'($urandom_range(0, 31));
            end
            send_request(p, d, 1'b0, REJECT_STEP);
            if (phase == 3 && n == 28) begin
               drain();
            end else if (idling && $urandom_range(99) < 20) begin
               gap = $urandom_range(1, 50);
               hold_off(gap);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d dispatch requests over %0d register writes: %0d floor steps",
               req_count, csr_count, step_count - rej_count);
      $display("checked, %0d rejected requests, clamped and extreme counts included.",
               rej_count);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout with %0d results still pending", trip_steps_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
